// File: rtl/flm_pkg.sv
// ----------------------------------------------------------------------------
// Flame histogram package
// Shared constants, register codes and the command word that passes from
// the front part to the back part of the histogram accumulator.
// ----------------------------------------------------------------------------
package flm_pkg;

  localparam int GRID_WIDTH_DEF  = 256;
  localparam int GRID_HEIGHT_DEF = 256;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int KEY_W           = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

  localparam logic MODE_HIT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic signed [31:0] LEFT_RST   = -32'sd65536;
  localparam logic signed [31:0] BOTTOM_RST = -32'sd65536;
  localparam logic [30:0]        WIDTH_RST  = 31'd131072;
  localparam logic [30:0]        HEIGHT_RST = 31'd131072;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] bottom;
    logic [30:0]        width;
    logic [30:0]        height;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic             ok;
    logic [KEY_W-1:0] key;
    logic [15:0]      ci;
  } cmd_t;

endpackage

// File: rtl/flm_if.sv
// ----------------------------------------------------------------------------
// Flame histogram channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface flm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [15:0]        color_index;
  logic [7:0]         pixel_x;
  logic [7:0]         pixel_y;

  modport source (output valid, mode, point_x, point_y, color_index, pixel_x, pixel_y,
                  input ready);
  modport sink   (input valid, mode, point_x, point_y, color_index, pixel_x, pixel_y,
                  output ready);
endinterface

interface flm_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [31:0] pixel_count;
  logic [15:0] pixel_intensity;
  logic [15:0] average_index;

  modport source (output valid, accepted, pixel_count, pixel_intensity, average_index,
                  input ready);
  modport sink   (input valid, accepted, pixel_count, pixel_intensity, average_index,
                  output ready);
endinterface

// File: rtl/flm_front.sv
// ----------------------------------------------------------------------------
// Flame histogram front
// Accepts items, tests the frame and bins hit points with radix-2 dividers.
// ----------------------------------------------------------------------------
module flm_front #(
  parameter int GRID_WIDTH  = flm_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = flm_pkg::GRID_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hold,
  input  flm_pkg::cfg_t cfg,
  flm_in_if.sink        in_ch,
  output logic          push,
  output flm_pkg::cmd_t push_data,
  input  logic          full
);
  import flm_pkg::*;

  localparam int XW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int YW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int NSTEP = (XW > YW) ? XW : YW;
  localparam int CW    = $clog2(NSTEP + 1);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_PREP = 5'b00010,
    F_MUL  = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } fst_t;

  fst_t               st;
  logic               mode;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic [15:0]        ci;
  logic [7:0]         pxl;
  logic [7:0]         pyl;
  logic               ok;
  logic [30:0]        dx;
  logic [30:0]        dy;
  logic [KEY_W-1:0]   kread;
  logic [30:0]        rx;
  logic [30:0]        ry;
  logic [XW-1:0]      lx;
  logic [YW-1:0]      ly;
  logic [XW-1:0]      qx;
  logic [YW-1:0]      qy;
  logic [CW-1:0]      cnt;

  logic [32:0]        dx_w;
  logic [32:0]        dy_w;
  logic               okx;
  logic               oky;
  logic [30+XW:0]     nx;
  logic [30+YW:0]     ny;
  logic [31:0]        tx;
  logic [31:0]        ty;
  logic               gex;
  logic               gey;

  assign in_ch.ready = (st == F_IDLE) && !hold;

  always_comb begin
    dx_w = {px[31], px} - {cfg.left[31], cfg.left};
    dy_w = {py[31], py} - {cfg.bottom[31], cfg.bottom};
    okx  = !dx_w[32] && (dx_w[31:0] < {1'b0, cfg.width});
    oky  = !dy_w[32] && (dy_w[31:0] < {1'b0, cfg.height});
    nx   = (31 + XW)'(dx) * (31 + XW)'(GRID_WIDTH);
    ny   = (31 + YW)'(dy) * (31 + YW)'(GRID_HEIGHT);
    tx   = {rx, lx[XW-1]};
    ty   = {ry, ly[YW-1]};
    gex  = tx >= {1'b0, cfg.width};
    gey  = ty >= {1'b0, cfg.height};
  end

  assign push = (st == F_PUSH) && !full;

  always_comb begin
    push_data.mode = mode;
    push_data.ok   = ok;
    push_data.ci   = ci;
    if (mode == MODE_READ) begin
      push_data.key = kread;
    end else begin
      push_data.key = KEY_W'(qy) * KEY_W'(GRID_WIDTH) + KEY_W'(qx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      case (st)
        F_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            mode <= in_ch.mode;
            px   <= in_ch.point_x;
            py   <= in_ch.point_y;
            ci   <= in_ch.color_index;
            pxl  <= in_ch.pixel_x;
            pyl  <= in_ch.pixel_y;
            st   <= F_PREP;
          end
        end
        F_PREP: begin
          if (mode == MODE_READ) begin
            ok    <= (32'(pxl) < 32'(GRID_WIDTH)) && (32'(pyl) < 32'(GRID_HEIGHT));
            kread <= KEY_W'(pyl) * KEY_W'(GRID_WIDTH) + KEY_W'(pxl);
            st    <= F_PUSH;
          end else begin
            ok <= okx && oky;
            dx <= dx_w[30:0];
            dy <= dy_w[30:0];
            st <= (okx && oky) ? F_MUL : F_PUSH;
          end
        end
        F_MUL: begin
          rx  <= nx[30+XW:XW];
          lx  <= nx[XW-1:0];
          ry  <= ny[30+YW:YW];
          ly  <= ny[YW-1:0];
          qx  <= '0;
          qy  <= '0;
          cnt <= '0;
          st  <= F_DIV;
        end
        F_DIV: begin
          // one quotient bit per cycle on each axis
          if (cnt < CW'(XW)) begin
            rx <= gex ? 31'(tx - {1'b0, cfg.width}) : tx[30:0];
            lx <= lx << 1;
            qx <= (qx << 1) | XW'(gex);
          end
          if (cnt < CW'(YW)) begin
            ry <= gey ? 31'(ty - {1'b0, cfg.height}) : ty[30:0];
            ly <= ly << 1;
            qy <= (qy << 1) | YW'(gey);
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NSTEP - 1)) begin
            st <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            st <= F_IDLE;
          end
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/flm_fifo.sv
// ----------------------------------------------------------------------------
// Flame histogram command queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module flm_fifo #(
  parameter int DEPTH = flm_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  flm_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output flm_pkg::cmd_t pop_data,
  output logic          empty
);
  import flm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [NW-1:0] fill;

  assign full     = fill == NW'(DEPTH);
  assign empty    = fill == '0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      fill <= fill + NW'(push) - NW'(pop);
    end
  end

endmodule

// File: rtl/flm_log2.sv
// ----------------------------------------------------------------------------
// Flame histogram log2 unit
// Fixed-point log2 with 32 fraction bits by normalizing and repeated squaring.
// ----------------------------------------------------------------------------
module flm_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] arg,
  output logic        done,
  output logic [37:0] result
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQR  = 3'b100
  } lst_t;

  lst_t        st;
  logic [32:0] m;
  logic [5:0]  e;
  logic [31:0] mant;
  logic [31:0] frac;
  logic [4:0]  step;
  logic [63:0] sq;

  assign sq     = mant * mant;
  assign result = {e, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == L_SQR) && (step == '0);
      case (st)
        L_IDLE: begin
          if (start) begin
            m    <= arg;
            e    <= 6'd32;
            frac <= '0;
            st   <= L_NORM;
          end
        end
        L_NORM: begin
          // shift left until the leading one sits at the top
          if (m[32]) begin
            mant <= m[32:1];
            step <= 5'd31;
            st   <= L_SQR;
          end else begin
            m <= m << 1;
            e <= e - 1'b1;
          end
        end
        L_SQR: begin
          if (sq[63]) begin
            mant <= sq[63:32];
            frac <= {frac[30:0], 1'b1};
          end else begin
            mant <= sq[62:31];
            frac <= {frac[30:0], 1'b0};
          end
          step <= step - 1'b1;
          if (step == '0) begin
            st <= L_IDLE;
          end
        end
        default: st <= L_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/flm_back.sv
// ----------------------------------------------------------------------------
// Flame histogram back
// Clears and updates the pixel stores, tracks the maximum and builds results.
// ----------------------------------------------------------------------------
module flm_back #(
  parameter int GRID_WIDTH  = flm_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = flm_pkg::GRID_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  output logic          pop,
  input  flm_pkg::cmd_t pop_data,
  input  logic          empty,
  output logic          clearing,
  flm_out_if.source     out_ch
);
  import flm_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int KW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [8:0] {
    B_CLEAR = 9'b000000001,
    B_IDLE  = 9'b000000010,
    B_FETCH = 9'b000000100,
    B_EXEC  = 9'b000001000,
    B_LOGC  = 9'b000010000,
    B_LOGM  = 9'b000100000,
    B_DIVI  = 9'b001000000,
    B_DIVA  = 9'b010000000,
    B_OUT   = 9'b100000000
  } bst_t;

  bst_t        st;
  logic [31:0] count_mem [CELLS];
  logic [47:0] sum_mem   [CELLS];
  logic [KW-1:0] clr_addr;
  cmd_t        cmd_q;
  logic [31:0] rd_cnt;
  logic [47:0] rd_sum;
  logic [31:0] max_count;
  logic [37:0] lc;
  logic [37:0] dv_rem;
  logic [37:0] dv_den;
  logic [16:0] dv_low;
  logic [16:0] dv_q;
  logic [4:0]  dv_cnt;
  logic        res_acc;
  logic [31:0] res_cnt;
  logic [15:0] res_int;
  logic [15:0] res_avg;
  logic        out_valid;
  logic        o_acc;
  logic [31:0] o_cnt;
  logic [15:0] o_int;
  logic [15:0] o_avg;

  logic          we;
  logic [KW-1:0] waddr;
  logic [31:0]   wcnt;
  logic [47:0]   wsum;
  logic          hit_ok;
  logic          log_start;
  logic [32:0]   log_arg;
  logic          log_done;
  logic [37:0]   log_res;
  logic [38:0]   dv_t;
  logic          dv_ge;
  logic [16:0]   dv_q_n;

  assign clearing = st == B_CLEAR;
  assign pop      = (st == B_IDLE) && !empty;

  assign hit_ok = (st == B_EXEC) && (cmd_q.mode == MODE_HIT) && cmd_q.ok && (rd_cnt != '1);
  assign we     = clearing || hit_ok;
  assign waddr  = clearing ? clr_addr : cmd_q.key[KW-1:0];
  assign wcnt   = clearing ? '0 : rd_cnt + 1'b1;
  assign wsum   = clearing ? '0 : rd_sum + 48'(cmd_q.ci);

  assign log_start = ((st == B_EXEC) && (cmd_q.mode == MODE_READ) && cmd_q.ok &&
                      (max_count != '0)) || ((st == B_LOGC) && log_done);
  assign log_arg   = (st == B_EXEC) ? {1'b0, rd_cnt} + 33'd1 : {1'b0, max_count} + 33'd1;

  assign dv_t   = {dv_rem, dv_low[16]};
  assign dv_ge  = dv_t >= {1'b0, dv_den};
  assign dv_q_n = {dv_q[15:0], dv_ge};

  flm_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .arg    (log_arg),
    .done   (log_done),
    .result (log_res)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[waddr] <= wcnt;
    end
    if (st == B_FETCH) begin
      rd_cnt <= count_mem[cmd_q.key[KW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sum_mem[waddr] <= wsum;
    end
    if (st == B_FETCH) begin
      rd_sum <= sum_mem[cmd_q.key[KW-1:0]];
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.accepted        = o_acc;
  assign out_ch.pixel_count     = o_cnt;
  assign out_ch.pixel_intensity = o_int;
  assign out_ch.average_index   = o_avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_CLEAR;
      clr_addr  <= '0;
      max_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((st == B_OUT) && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == KW'(CELLS - 1)) begin
            st <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            cmd_q <= pop_data;
            st    <= B_FETCH;
          end
        end
        B_FETCH: st <= B_EXEC;
        B_EXEC: begin
          res_acc <= cmd_q.ok;
          res_cnt <= ((cmd_q.mode == MODE_READ) && cmd_q.ok) ? rd_cnt : '0;
          res_int <= '0;
          res_avg <= '0;
          if (hit_ok && (wcnt > max_count)) begin
            max_count <= wcnt;
          end
          if ((cmd_q.mode == MODE_HIT) || !cmd_q.ok) begin
            st <= B_OUT;
          end else begin
            if (max_count != '0) begin
              st <= B_LOGC;
            end else if (rd_cnt != '0) begin
              dv_rem <= {6'd0, rd_sum[47:16]};
              dv_den <= {6'd0, rd_cnt};
              dv_low <= {rd_sum[15:0], 1'b0};
              dv_q   <= '0;
              dv_cnt <= 5'd15;
              st     <= B_DIVA;
            end else begin
              st <= B_OUT;
            end
          end
        end
        B_LOGC: begin
          if (log_done) begin
            lc <= log_res;
            st <= B_LOGM;
          end
        end
        B_LOGM: begin
          if (log_done) begin
            dv_rem <= {1'b0, lc[37:1]};
            dv_den <= log_res;
            dv_low <= {lc[0], 16'd0};
            dv_q   <= '0;
            dv_cnt <= 5'd16;
            st     <= B_DIVI;
          end
        end
        B_DIVI: begin
          if (dv_cnt != '0) begin
            dv_rem <= dv_ge ? 38'(dv_t - {1'b0, dv_den}) : dv_t[37:0];
            dv_low <= dv_low << 1;
            dv_q   <= dv_q_n;
            dv_cnt <= dv_cnt - 1'b1;
          end else begin
            res_int <= dv_q_n[16] ? 16'hFFFF : dv_q_n[15:0];
            if (rd_cnt != '0) begin
              dv_rem <= {6'd0, rd_sum[47:16]};
              dv_den <= {6'd0, rd_cnt};
              dv_low <= {rd_sum[15:0], 1'b0};
              dv_q   <= '0;
              dv_cnt <= 5'd15;
              st     <= B_DIVA;
            end else begin
              st <= B_OUT;
            end
          end
        end
        B_DIVA: begin
          dv_rem <= dv_ge ? 38'(dv_t - {1'b0, dv_den}) : dv_t[37:0];
          dv_low <= dv_low << 1;
          dv_q   <= dv_q_n;
          dv_cnt <= dv_cnt - 1'b1;
          if (dv_cnt == '0) begin
            res_avg <= dv_q_n[15:0];
            st      <= B_OUT;
          end
        end
        B_OUT: begin
          // load the output register once the previous beat has left
          if (!out_valid || out_ch.ready) begin
            o_acc <= res_acc;
            o_cnt <= res_cnt;
            o_int <= res_int;
            o_avg <= res_avg;
            st    <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  a_max_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> max_count >= $past(max_count))
    else $error("max count went down");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("queue popped during clearing pass");

  a_hit_write_nonzero: assert property (@(posedge clk) disable iff (rst)
    hit_ok |-> wcnt != '0)
    else $error("hit wrote a zero count");

  a_log_start_state: assert property (@(posedge clk) disable iff (rst)
    log_start |-> (st == B_EXEC || st == B_LOGC))
    else $error("log unit started outside a read");

endmodule

// File: rtl/flame_histogram_accumulator_core.sv
// ----------------------------------------------------------------------------
// Flame histogram accumulator core
// Per-pixel hit count and color-index sum with log-density read-out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per item: mode 0 bins a Q16.16 point into the
//   grid and raises that pixel's count and index sum; mode 1 reads one pixel.
//   out_ch returns exactly one result beat per input beat, in order.
//   cfg_we/cfg_index/cfg_data write the frame registers; write them only
//   while the block is idle.
// Flow:
//   An in-frame hit passes through the radix-2 bin division in the front and
//   the read-modify-write of the pixel stores. A read may use the shared log2
//   unit (two logs, each by normalizing and repeated squaring) and the radix-2
//   divider for intensity and average.
// Reset:
//   After rst the back sweeps both stores to zero, one pixel per cycle,
//   over all GRID_WIDTH * GRID_HEIGHT pixels; in_ch.ready stays low until done.
// Stall:
//   A result waits in the output register; the front keeps taking beats
//   into the command queue until it fills, then drops ready.
// ----------------------------------------------------------------------------
module flame_histogram_accumulator_core #(
  parameter int GRID_WIDTH  = flm_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = flm_pkg::GRID_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [flm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flm_pkg::CFG_DATA_W-1:0] cfg_data,
  flm_in_if.sink                         in_ch,
  flm_out_if.source                      out_ch
);
  import flm_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t pop_data;
  logic empty;
  logic clearing;

  // frame registers; unknown indexes fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left   <= LEFT_RST;
      cfg.bottom <= BOTTOM_RST;
      cfg.width  <= WIDTH_RST;
      cfg.height <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LEFT:   cfg.left   <= cfg_data;
        CFG_FRAME_BOTTOM: cfg.bottom <= cfg_data;
        CFG_FRAME_WIDTH:  cfg.width  <= cfg_data[30:0];
        CFG_FRAME_HEIGHT: cfg.height <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // front: accept, test the frame, bin the point
  flm_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // queue: decouple binning from the store update
  flm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // back: clear, update stores, compute read-out
  flm_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
